FILE: hw/rtl/rs485dc_pkg.sv
// Shared types, codes and reset constants for the RS-485 direction control block.
`timescale 1ns / 1ps
`default_nettype none

package rs485dc_pkg;

   // Receive FIFO depth used when the top level is not overridden
   localparam int FIFO_DEPTH_DEFAULT = 128;

   // Field widths of the channels
   localparam int KIND_W     = 3;
   localparam int BYTE_W     = 8;
   localparam int LENGTH_W   = 16;
   localparam int COUNT_W    = 7;
   localparam int STATUS_W   = 2;
   localparam int TICKS_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [TICKS_W-1:0] BUS_RELEASE_RESET   = TICKS_W'(12000);
   localparam logic [TICKS_W-1:0] DRIVER_SETTLE_RESET = TICKS_W'(200);
   localparam logic [TICKS_W-1:0] RX_SETTLE_RESET     = TICKS_W'(50);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BUS_RELEASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVER_SETTLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_SETTLE     = 2'd2;

   // Send status codes
   localparam logic [STATUS_W-1:0] SEND_NONE   = 2'd0;
   localparam logic [STATUS_W-1:0] SEND_REJECT = 2'd1;
   localparam logic [STATUS_W-1:0] SEND_DONE   = 2'd2;

   // Request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 3'd0,
      KIND_RX_BYTE = 3'd1,
      KIND_READ    = 3'd2,
      KIND_CLEAR   = 3'd3,
      KIND_SEND    = 3'd4,
      KIND_TX_DONE = 3'd5
   } kind_type;

   // Direction phases
   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_RELEASE    = 3'd1,
      PH_DRV_SETTLE = 3'd2,
      PH_TX         = 3'd3,
      PH_RX_SETTLE  = 3'd4
   } phase_type;

   // Sequencer result for one item
   typedef struct packed {
      logic                driver_enable;
      logic                busy;
      logic                tx_start;
      logic [LENGTH_W-1:0] tx_length;
      logic [STATUS_W-1:0] send_status;
   } seq_res_type;

   // FIFO result for one item (read byte comes separately from the memory)
   typedef struct packed {
      logic               read_valid;
      logic [COUNT_W-1:0] fifo_count;
      logic               byte_dropped;
   } fifo_res_type;

   // Full response
   typedef struct packed {
      seq_res_type        seq;
      fifo_res_type       fifo;
      logic [BYTE_W-1:0]  read_data;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rs485dc_ifs.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
`default_nettype none

interface rs485dc_req_if
   import rs485dc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [BYTE_W-1:0]   rx_data;
   logic [LENGTH_W-1:0] frame_length;

   modport source (output valid, output kind, output rx_data, output frame_length,
                   input ready);
   modport sink   (input valid, input kind, input rx_data, input frame_length,
                   output ready);
endinterface

interface rs485dc_rsp_if
   import rs485dc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                driver_enable;
   logic                busy_res;
   logic                read_valid;
   logic [BYTE_W-1:0]   read_data;
   logic [COUNT_W-1:0]  fifo_count;
   logic                byte_dropped;
   logic                tx_start;
   logic [LENGTH_W-1:0] tx_length;
   logic [STATUS_W-1:0] send_status;

   modport source (output valid, output driver_enable, output busy_res,
                   output read_valid, output read_data, output fifo_count,
                   output byte_dropped, output tx_start, output tx_length,
                   output send_status, input ready);
   modport sink   (input valid, input driver_enable, input busy_res,
                   input read_valid, input read_data, input fifo_count,
                   input byte_dropped, input tx_start, input tx_length,
                   input send_status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rs485dc_seq.sv
// Driver enable sequencer: phase register, tick counter and timing registers.
`timescale 1ns / 1ps
`default_nettype none

module rs485dc_seq
   import rs485dc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire kind_type              kind,
   input  wire logic [LENGTH_W-1:0]   frame_length,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rx_open,
   output seq_res_type                res
);

   phase_type           phase_ff, phase_in;
   logic [TICKS_W-1:0]  wait_ff, wait_in;
   logic [LENGTH_W-1:0] pend_ff, pend_in;
   logic [TICKS_W-1:0]  bus_release_ff, driver_settle_ff, rx_settle_ff;
   logic [TICKS_W-1:0]  wait_dec;

   // Timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_release_ff   <= BUS_RELEASE_RESET;
         driver_settle_ff <= DRIVER_SETTLE_RESET;
         rx_settle_ff     <= RX_SETTLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BUS_RELEASE:   bus_release_ff   <= csr_wdata;
            CSR_DRIVER_SETTLE: driver_settle_ff <= csr_wdata;
            CSR_RX_SETTLE:     rx_settle_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Receiver is live while the driver has not yet been raised
   assign rx_open  = (phase_ff == PH_IDLE) || (phase_ff == PH_RELEASE);
   assign wait_dec = (wait_ff != '0) ? wait_ff - 1'b1 : wait_ff;

   // Next phase and per-item result
   always_comb begin
      phase_in        = phase_ff;
      wait_in         = wait_ff;
      pend_in         = pend_ff;
      res.tx_start    = 1'b0;
      res.tx_length   = '0;
      res.send_status = SEND_NONE;
      case (kind)
         KIND_TICK: begin
            if (phase_ff == PH_RELEASE || phase_ff == PH_DRV_SETTLE ||
                phase_ff == PH_RX_SETTLE) begin
               wait_in = wait_dec;
               if (wait_dec == '0) begin
                  case (phase_ff)
                     PH_RELEASE: begin
                        phase_in = PH_DRV_SETTLE;
                        wait_in  = driver_settle_ff;
                     end
                     PH_DRV_SETTLE: begin
                        phase_in      = PH_TX;
                        res.tx_start  = 1'b1;
                        res.tx_length = pend_ff;
                     end
                     default: begin
                        phase_in        = PH_IDLE;
                        res.send_status = SEND_DONE;
                     end
                  endcase
               end
            end
         end
         KIND_SEND: begin
            if (phase_ff != PH_IDLE || frame_length == '0) begin
               res.send_status = SEND_REJECT;
            end else begin
               phase_in = PH_RELEASE;
               wait_in  = bus_release_ff;
               pend_in  = frame_length;
            end
         end
         KIND_TX_DONE: begin
            if (phase_ff == PH_TX) begin
               phase_in = PH_RX_SETTLE;
               wait_in  = rx_settle_ff;
            end
         end
         default: ;
      endcase
      res.driver_enable = (phase_in == PH_DRV_SETTLE) || (phase_in == PH_TX);
      res.busy          = (phase_in != PH_IDLE);
   end

   // Phase state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wait_ff  <= '0;
         pend_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rs485dc_fifo.sv
// Receive ring FIFO: byte memory with registered read and head/tail pointers.
`timescale 1ns / 1ps
`default_nettype none

module rs485dc_fifo
   import rs485dc_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire kind_type          kind,
   input  wire logic [BYTE_W-1:0] rx_data,
   input  wire logic              rx_open,
   output fifo_res_type           res,
   output logic [BYTE_W-1:0]      rd_data
);

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam logic [AW-1:0] LAST    = AW'(FIFO_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(FIFO_DEPTH);

   logic [BYTE_W-1:0] mem [FIFO_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [AW-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0]     head_nx, tail_nx;
   logic              wr_en, rd_en;
   logic [AW:0]       len;

   assign head_nx = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign tail_nx = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;

   // Pointer update; one slot stays empty to tell full from empty
   always_comb begin
      head_in          = head_ff;
      tail_in          = tail_ff;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      res.byte_dropped = 1'b0;
      case (kind)
         KIND_RX_BYTE: begin
            if (rx_open && head_nx != tail_ff) begin
               wr_en   = accept;
               head_in = head_nx;
            end else begin
               res.byte_dropped = 1'b1;
            end
         end
         KIND_READ: begin
            if (tail_ff != head_ff) begin
               rd_en   = accept;
               tail_in = tail_nx;
            end
         end
         KIND_CLEAR: begin
            head_in = '0;
            tail_in = '0;
         end
         default: ;
      endcase
      res.read_valid = (kind == KIND_READ) && (tail_ff != head_ff);
   end

   // Fill level after this item
   assign len = (head_in >= tail_in) ? {1'b0, head_in} - {1'b0, tail_in}
                                     : DEPTH_W - {1'b0, tail_in} + {1'b0, head_in};
   assign res.fifo_count = COUNT_W'(len);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else if (accept) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // Byte memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[head_ff] <= rx_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[tail_ff];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rs485_direction_control_rx_fifo_unit.sv
// Top level of the RS-485 direction control and receive FIFO block.
// Takes one request per clock cycle unless responses back up. Each request
// gives exactly one response. Accepting it updates the phase registers and
// pointers and issues the FIFO memory read; the result stage holds the read
// byte and the rest of the result; a response register behind it lets requests
// keep flowing while a response waits. Timing registers are to be written
// through the csr port while the block is idle; the block does not enforce
// this. They are used at the next counter load. FIFO_DEPTH slots hold at most
// FIFO_DEPTH-1 bytes; fifo_count gives the level's low seven bits.
`timescale 1ns / 1ps
`default_nettype none

module rs485_direction_control_rx_fifo_unit
   import rs485dc_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rs485dc_req_if.sink                req_bus,
   rs485dc_rsp_if.source              rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic              accept;
   logic              s1_adv;
   kind_type          kind;
   logic              rx_open;
   seq_res_type       seq_res;
   fifo_res_type      fifo_res;
   logic [BYTE_W-1:0] rd_data;

   logic              s1_v_ff, s1_v_in;
   seq_res_type       s1_seq_ff;
   fifo_res_type      s1_fifo_ff;
   logic              out_v_ff, out_v_in;
   rsp_type           out_ff;

   // Handshake
   assign s1_adv        = !out_v_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_v_ff || s1_adv;
   assign accept        = req_bus.valid && req_bus.ready;
   assign kind          = kind_type'(req_bus.kind);

   rs485dc_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (kind),
      .frame_length (req_bus.frame_length),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rx_open      (rx_open),
      .res          (seq_res)
   );

   rs485dc_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .kind    (kind),
      .rx_data (req_bus.rx_data),
      .rx_open (rx_open),
      .res     (fifo_res),
      .rd_data (rd_data)
   );

   // Valid bits of the result stage and the response register
   assign s1_v_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_ff);
   assign out_v_in = s1_adv ? s1_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Result stage waits for the memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_seq_ff  <= seq_res;
         s1_fifo_ff <= fifo_res;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (s1_adv && s1_v_ff) begin
         out_ff.seq       <= s1_seq_ff;
         out_ff.fifo      <= s1_fifo_ff;
         out_ff.read_data <= s1_fifo_ff.read_valid ? rd_data : '0;
      end
   end

   assign rsp_bus.valid         = out_v_ff;
   assign rsp_bus.driver_enable = out_ff.seq.driver_enable;
   assign rsp_bus.busy_res      = out_ff.seq.busy;
   assign rsp_bus.read_valid    = out_ff.fifo.read_valid;
   assign rsp_bus.read_data     = out_ff.read_data;
   assign rsp_bus.fifo_count    = out_ff.fifo.fifo_count;
   assign rsp_bus.byte_dropped  = out_ff.fifo.byte_dropped;
   assign rsp_bus.tx_start      = out_ff.seq.tx_start;
   assign rsp_bus.tx_length     = out_ff.seq.tx_length;
   assign rsp_bus.send_status   = out_ff.seq.send_status;

endmodule

`default_nettype wire

FILE: hw/rtl/rs485dc_checker.sv
// Port-level checks on the response channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rs485dc_checker
   import rs485dc_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                driver_enable,
   input wire logic                busy_res,
   input wire logic                read_valid,
   input wire logic [BYTE_W-1:0]   read_data,
   input wire logic                tx_start,
   input wire logic [LENGTH_W-1:0] tx_length,
   input wire logic [STATUS_W-1:0] send_status
);

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Transmission starts only with the driver on and a sequence running
   a_start_driven: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && tx_start |-> driver_enable && busy_res && tx_length != '0)
      else $error("tx_start without driver enable");

   // A completed sequence leaves the bus released
   a_done_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && send_status == SEND_DONE |-> !busy_res && !driver_enable)
      else $error("completion reported with bus still held");

   // Data fields read zero when not carried
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (read_valid || read_data == '0) && (tx_start || tx_length == '0))
      else $error("stray read_data or tx_length");

   // The driver is never on outside a sequence
   a_driver_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && driver_enable |-> busy_res)
      else $error("driver enabled while idle");

endmodule

bind rs485_direction_control_rx_fifo_unit rs485dc_checker u_rs485dc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .driver_enable (rsp_bus.driver_enable),
   .busy_res      (rsp_bus.busy_res),
   .read_valid    (rsp_bus.read_valid),
   .read_data     (rsp_bus.read_data),
   .tx_start      (rsp_bus.tx_start),
   .tx_length     (rsp_bus.tx_length),
   .send_status   (rsp_bus.send_status)
);

`default_nettype wire
